>>> hw/rtl/tsa_pkg.sv
package tsa_pkg;

  localparam int COORD_BITS = 16;

  // difference of two coordinates, then its square and the cross terms
  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int SQ_W    = 2 * COORD_BITS;
  localparam int SUM_W   = SQ_W + 1;
  localparam int CROSS_W = PROD_W + 1;

  // radicand is 100 * (dx^2 + dy^2); 100 < 2^7
  localparam int ROOT_W = (SUM_W + 7 + 1) / 2;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 2;

  localparam int SIDE_W = 20;
  localparam int AREA_W = 32;

  localparam int FRONT_STAGES = 4;
  localparam int NSTAGE       = FRONT_STAGES + ROOT_W + 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic        [SQ_W-1:0]       sq_t;
  typedef logic        [SUM_W-1:0]      sum_t;
  typedef logic signed [CROSS_W-1:0]    cross_t;
  typedef logic        [RAD_W-1:0]      rad_t;
  typedef logic        [REM_W-1:0]      rem_t;
  typedef logic        [ROOT_W-1:0]     root_t;
  typedef logic        [SIDE_W-1:0]     side_t;
  typedef logic        [AREA_W-1:0]     area_t;

  typedef struct packed {
    rad_t  n_ab;
    rad_t  n_bc;
    rad_t  n_ac;
    area_t area;
  } front_out_t;

endpackage

>>> hw/rtl/tsa_ifs.sv
interface tsa_in_if import tsa_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t ax;
  coord_t ay;
  coord_t bx;
  coord_t by;
  coord_t cx;
  coord_t cy;

  modport source (output valid, output ax, output ay, output bx, output by, output cx,
                  output cy, input ready);
  modport sink (input valid, input ax, input ay, input bx, input by, input cx,
                input cy, output ready);
endinterface

interface tsa_out_if import tsa_pkg::*; ();
  logic  valid;
  logic  ready;
  side_t side_ab;
  side_t side_bc;
  side_t side_ac;
  area_t area;

  modport source (output valid, output side_ab, output side_bc, output side_ac,
                  output area, input ready);
  modport sink (input valid, input side_ab, input side_bc, input side_ac,
                input area, output ready);
endinterface

>>> hw/rtl/tsa_front.sv
module tsa_front import tsa_pkg::*; (
  input  logic                    clk,
  input  logic [FRONT_STAGES-1:0] en,
  input  coord_t                  ax,
  input  coord_t                  ay,
  input  coord_t                  bx,
  input  coord_t                  by,
  input  coord_t                  cx,
  input  coord_t                  cy,
  output front_out_t              res
);

  diff_t d_abx_r, d_aby_r, d_bcx_r, d_bcy_r, d_acx_r, d_acy_r;
  sq_t   s_abx_r, s_aby_r, s_bcx_r, s_bcy_r, s_acx_r, s_acy_r;
  prod_t cp1_r, cp2_r;
  sum_t  sum_ab_r, sum_bc_r, sum_ac_r;
  cross_t cross_r;
  front_out_t res_r;

  prod_t p_abx, p_aby, p_bcx, p_bcy, p_acx, p_acy, p_c1, p_c2;
  logic [CROSS_W-1:0] acr, half;
  rad_t n_ab, n_bc, n_ac;

  assign p_abx = d_abx_r * d_abx_r;
  assign p_aby = d_aby_r * d_aby_r;
  assign p_bcx = d_bcx_r * d_bcx_r;
  assign p_bcy = d_bcy_r * d_bcy_r;
  assign p_acx = d_acx_r * d_acx_r;
  assign p_acy = d_acy_r * d_acy_r;
  // (B-A)x(C-A) equals (A-B)x(A-C), so the side differences serve the cross product
  assign p_c1  = d_abx_r * d_acy_r;
  assign p_c2  = d_aby_r * d_acx_r;

  // times 100 as 64 + 32 + 4
  assign n_ab = (RAD_W'(sum_ab_r) << 6) + (RAD_W'(sum_ab_r) << 5) + (RAD_W'(sum_ab_r) << 2);
  assign n_bc = (RAD_W'(sum_bc_r) << 6) + (RAD_W'(sum_bc_r) << 5) + (RAD_W'(sum_bc_r) << 2);
  assign n_ac = (RAD_W'(sum_ac_r) << 6) + (RAD_W'(sum_ac_r) << 5) + (RAD_W'(sum_ac_r) << 2);

  // half of |cross|, ties away from zero
  assign acr  = cross_r[CROSS_W-1] ? CROSS_W'(-cross_r) : CROSS_W'(cross_r);
  assign half = (acr + CROSS_W'(1)) >> 1;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      d_abx_r <= DIFF_W'(ax) - DIFF_W'(bx);
      d_aby_r <= DIFF_W'(ay) - DIFF_W'(by);
      d_bcx_r <= DIFF_W'(bx) - DIFF_W'(cx);
      d_bcy_r <= DIFF_W'(by) - DIFF_W'(cy);
      d_acx_r <= DIFF_W'(ax) - DIFF_W'(cx);
      d_acy_r <= DIFF_W'(ay) - DIFF_W'(cy);
    end
    if (en[1]) begin
      s_abx_r <= p_abx[SQ_W-1:0];
      s_aby_r <= p_aby[SQ_W-1:0];
      s_bcx_r <= p_bcx[SQ_W-1:0];
      s_bcy_r <= p_bcy[SQ_W-1:0];
      s_acx_r <= p_acx[SQ_W-1:0];
      s_acy_r <= p_acy[SQ_W-1:0];
      cp1_r   <= p_c1;
      cp2_r   <= p_c2;
    end
    if (en[2]) begin
      sum_ab_r <= SUM_W'(s_abx_r) + SUM_W'(s_aby_r);
      sum_bc_r <= SUM_W'(s_bcx_r) + SUM_W'(s_bcy_r);
      sum_ac_r <= SUM_W'(s_acx_r) + SUM_W'(s_acy_r);
      cross_r  <= CROSS_W'(cp1_r) - CROSS_W'(cp2_r);
    end
    if (en[3]) begin
      res_r.n_ab <= n_ab;
      res_r.n_bc <= n_bc;
      res_r.n_ac <= n_ac;
      res_r.area <= half[AREA_W-1:0];
    end
  end

  assign res = res_r;

endmodule

>>> hw/rtl/tsa_root_step.sv
module tsa_root_step import tsa_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  rem_t  rem_i,
  input  root_t root_i,
  input  rad_t  rad_i,
  output rem_t  rem_o,
  output root_t root_o,
  output rad_t  rad_o
);

  rem_t  rem_r, rem_nxt, rem_sh, trial;
  root_t root_r, root_nxt;
  rad_t  rad_r;
  logic  ge;

  // bring down the next two radicand bits and try root*4+1
  assign rem_sh   = {rem_i[REM_W-3:0], rad_i[RAD_W-1 -: 2]};
  assign trial    = {root_i, 2'b01};
  assign ge       = rem_sh >= trial;
  assign rem_nxt  = ge ? rem_sh - trial : rem_sh;
  assign root_nxt = {root_i[ROOT_W-2:0], ge};

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      rad_r  <= rad_i << 2;
    end
  end

  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign rad_o  = rad_r;

endmodule

>>> hw/rtl/tsa_isqrt.sv
module tsa_isqrt import tsa_pkg::*; (
  input  logic            clk,
  input  logic [ROOT_W:0] en,
  input  rad_t            n,
  output side_t           side
);

  rem_t  rem_w  [0:ROOT_W];
  root_t root_w [0:ROOT_W];
  rad_t  rad_w  [0:ROOT_W];
  root_t side_r;
  logic  up;

  assign rem_w[0]  = '0;
  assign root_w[0] = '0;
  assign rad_w[0]  = n;

  for (genvar i = 0; i < ROOT_W; i++) begin : g_step
    tsa_root_step u_step (
      .clk    (clk),
      .en     (en[i]),
      .rem_i  (rem_w[i]),
      .root_i (root_w[i]),
      .rad_i  (rad_w[i]),
      .rem_o  (rem_w[i+1]),
      .root_o (root_w[i+1]),
      .rad_o  (rad_w[i+1])
    );
  end

  // round up when n - r^2 exceeds r; ties cannot occur
  assign up = rem_w[ROOT_W] > REM_W'(root_w[ROOT_W]);

  always_ff @(posedge clk) begin
    if (en[ROOT_W]) begin
      side_r <= root_w[ROOT_W] + ROOT_W'(up);
    end
  end

  assign side = SIDE_W'(side_r);

endmodule

>>> hw/rtl/triangle_sides_and_area_unit.sv
// channel  | dir | beat fields                          | handshake
// in_ch    | in  | ax ay bx by cx cy (signed tenths)    | valid / ready
// out_ch   | out | side_ab side_bc side_ac area (1/100) | valid / ready
//
// One beat per cycle in and out while out_ch is not stalled; the pipeline is four arithmetic stages,
// the 20-stage square root pipeline (one root bit per stage) and a rounding stage.
// Reset clears only the per-stage valid bits.
// A stalled output holds its beat; earlier stages keep advancing into empty
// slots, and in_ch.ready drops only once every stage holds a beat.
// out_ch.ready reaches in_ch.ready through combinational logic.
module triangle_sides_and_area_unit import tsa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  tsa_in_if.sink    in_ch,
  tsa_out_if.source out_ch
);

  logic [NSTAGE-1:0] v_r, v_nxt, v_in, en;
  area_t             area_r [0:ROOT_W];
  front_out_t        front_res;
  side_t             side_ab, side_bc, side_ac;

  // a stage may load when it is empty or its contents move on
  assign en[NSTAGE-1] = !v_r[NSTAGE-1] || out_ch.ready;
  for (genvar k = 0; k < NSTAGE - 1; k++) begin : g_en
    assign en[k] = !v_r[k] || en[k+1];
  end

  assign v_in = {v_r[NSTAGE-2:0], in_ch.valid};

  always_comb begin
    for (int k = 0; k < NSTAGE; k++) begin
      v_nxt[k] = en[k] ? v_in[k] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  tsa_front u_front (
    .clk (clk),
    .en  (en[FRONT_STAGES-1:0]),
    .ax  (in_ch.ax),
    .ay  (in_ch.ay),
    .bx  (in_ch.bx),
    .by  (in_ch.by),
    .cx  (in_ch.cx),
    .cy  (in_ch.cy),
    .res (front_res)
  );

  tsa_isqrt u_sqrt_ab (
    .clk  (clk),
    .en   (en[NSTAGE-1:FRONT_STAGES]),
    .n    (front_res.n_ab),
    .side (side_ab)
  );

  tsa_isqrt u_sqrt_bc (
    .clk  (clk),
    .en   (en[NSTAGE-1:FRONT_STAGES]),
    .n    (front_res.n_bc),
    .side (side_bc)
  );

  tsa_isqrt u_sqrt_ac (
    .clk  (clk),
    .en   (en[NSTAGE-1:FRONT_STAGES]),
    .n    (front_res.n_ac),
    .side (side_ac)
  );

  // carry the area alongside the root pipeline
  always_ff @(posedge clk) begin
    if (en[FRONT_STAGES]) begin
      area_r[0] <= front_res.area;
    end
    for (int j = 1; j <= ROOT_W; j++) begin
      if (en[FRONT_STAGES + j]) begin
        area_r[j] <= area_r[j-1];
      end
    end
  end

  assign in_ch.ready    = en[0];
  assign out_ch.valid   = v_r[NSTAGE-1];
  assign out_ch.side_ab = side_ab;
  assign out_ch.side_bc = side_bc;
  assign out_ch.side_ac = side_ac;
  assign out_ch.area    = area_r[ROOT_W];

endmodule

>>> hw/rtl/tsa_checker.sv
module tsa_checker import tsa_pkg::*; (
  input logic  clk,
  input logic  rst_n,
  input logic  in_ready,
  input logic  out_valid,
  input logic  out_ready,
  input side_t side_ab,
  input side_t side_bc,
  input side_t side_ac,
  input area_t area
);

  // input backpressure comes only from a full pipe behind a stalled output
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  // rounded side_ac still obeys the triangle inequality against side_ab + side_bc within one hundredth
  a_triangle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(side_ac) <= 32'(side_ab) + 32'(side_bc) + 32'd1)
    else $error("side_ac exceeds side_ab + side_bc");

  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat dropped while stalled");

  a_beat_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(side_ab) && $stable(side_bc) &&
                                $stable(side_ac) && $stable(area))
    else $error("output beat changed while stalled");

endmodule

bind triangle_sides_and_area_unit tsa_checker u_tsa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .side_ab   (out_ch.side_ab),
  .side_bc   (out_ch.side_bc),
  .side_ac   (out_ch.side_ac),
  .area      (out_ch.area)
);
